/* src/nbpf_pkg.sv */
// Shared types, codes and defaults for the n-body pair filter enumerator.
`timescale 1ns / 1ps
package nbpf_pkg;

    localparam int BODY_COUNT_DEF = 32;

    // Item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // Interaction modes
    localparam logic [2:0] MODE_ALL          = 3'd0;
    localparam logic [2:0] MODE_NO_MOON_MOON = 3'd1;
    localparam logic [2:0] MODE_SAME_PARENT  = 3'd2;
    localparam logic [2:0] MODE_LOCAL_SYS    = 3'd3;
    localparam logic [2:0] MODE_PARENT_SUN   = 3'd4;

    typedef struct packed {
        logic       cmd;
        logic [4:0] entry_slot;
        logic       body_enabled;
        logic       body_is_moon;
        logic [4:0] parent_body;
    } t_item_in;

    typedef struct packed {
        logic [4:0] first_body;
        logic [4:0] second_body;
        logic       pair_valid;
        logic       scan_done;
        logic [8:0] pairs_emitted;
    } t_item_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd_row;
        logic cap_row;
        logic next_row;
        logic next_col;
        logic emit_pair;
        logic emit_done;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_load;
        logic row_last;
        logic row_en;
        logic col_end;
        logic col_en;
        logic kept;
    } t_dp_stat;

endpackage

/* src/nbpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nbpf_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/nbpf_ctrl.sv */
// Scan controller: sequences loads, row fetches and candidate checks.
`timescale 1ns / 1ps
module nbpf_ctrl
    import nbpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ROW     = 3'd1;
    localparam logic [2:0] S_ROW_CAP = 3'd2;
    localparam logic [2:0] S_COL     = 3'd3;
    localparam logic [2:0] S_EVAL    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.is_load) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        n_state = S_ROW;
                    end
                end
            end
            S_ROW: begin
                if (i_stat.row_last) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_IDLE;
                end else if (!i_stat.row_en) begin
                    o_cmd.next_row = 1'b1;
                end else begin
                    o_cmd.rd_row = 1'b1;
                    n_state      = S_ROW_CAP;
                end
            end
            S_ROW_CAP: begin
                o_cmd.cap_row = 1'b1;
                n_state       = S_COL;
            end
            S_COL: begin
                // the column entry is read here unless the row is exhausted
                if (i_stat.col_end) begin
                    o_cmd.next_row = 1'b1;
                    n_state        = S_ROW;
                end else if (!i_stat.col_en) begin
                    o_cmd.next_col = 1'b1;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.kept) begin
                    o_cmd.emit_pair = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.next_col = 1'b1;
                    n_state        = S_COL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/nbpf_dp.sv */
// Datapath: body table, scan cursors, pair filter and result register.
`timescale 1ns / 1ps
module nbpf_dp
    import nbpf_pkg::*;
#(
    parameter int BODY_COUNT = BODY_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item_in  i_item,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_result_strobe,
    output t_item_out o_result
);

    localparam int IW = $clog2(BODY_COUNT);
    localparam int JW = $clog2(BODY_COUNT + 1);
    localparam int CW = (IW > 5) ? IW : 5;
    localparam int XW = (JW > 5) ? JW : 5;
    localparam int EN_DEPTH = 1 << IW;

    logic [IW-1:0]       r_i;
    logic [JW-1:0]       r_j;
    logic [8:0]          r_count;
    logic [2:0]          r_mode;
    logic [EN_DEPTH-1:0] r_en;
    logic                r_row_moon;
    logic [4:0]          r_row_parent;
    logic                r_strobe;
    t_item_out           r_result;

    logic [XW-1:0] idx_ext;
    logic          idx_ok;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic [5:0]    ram_rdata;
    logic          col_moon;
    logic [4:0]    col_parent;
    logic [CW-1:0] i_ext;
    logic [CW-1:0] j_ext;
    logic [CW-1:0] par_i;
    logic [CW-1:0] par_j;
    logic [CW-1:0] sys_i;
    logic [CW-1:0] sys_j;
    logic          kept;
    logic [8:0]    count_inc;

    assign idx_ext = XW'(i_item.entry_slot);
    assign idx_ok  = (idx_ext < XW'(BODY_COUNT));
    assign wr_addr = idx_ext[IW-1:0];
    assign rd_addr = i_cmd.rd_row ? r_i : r_j[IW-1:0];

    nbpf_ram #(
        .WIDTH (6),
        .DEPTH (BODY_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && idx_ok),
        .i_waddr (wr_addr),
        .i_wdata ({i_item.body_is_moon, i_item.parent_body}),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign col_moon   = ram_rdata[5];
    assign col_parent = ram_rdata[4:0];

    assign i_ext = CW'(r_i);
    assign j_ext = CW'(r_j[IW-1:0]);
    assign par_i = CW'(r_row_parent);
    assign par_j = CW'(col_parent);
    assign sys_i = r_row_moon ? par_i : i_ext;
    assign sys_j = col_moon ? par_j : j_ext;

    // Second body is always above the first, so only the first can be the sun
    always_comb begin
        case (r_mode)
            MODE_NO_MOON_MOON: kept = !(r_row_moon && col_moon);
            MODE_SAME_PARENT:  kept = !(r_row_moon && col_moon) || (par_i == par_j);
            MODE_LOCAL_SYS:    kept = (r_i == '0) || (!r_row_moon && !col_moon)
                                   || (sys_i == sys_j);
            MODE_PARENT_SUN:   kept = (r_i == '0) || (!r_row_moon && !col_moon)
                                   || (col_moon && (par_j == i_ext))
                                   || (r_row_moon && (par_i == j_ext));
            default:           kept = 1'b1;
        endcase
    end

    assign o_stat.is_load  = (i_item.cmd == CMD_LOAD);
    assign o_stat.row_last = (JW'(r_i) + JW'(1) >= JW'(BODY_COUNT));
    assign o_stat.row_en   = r_en[r_i];
    assign o_stat.col_end  = (r_j >= JW'(BODY_COUNT));
    assign o_stat.col_en   = r_en[r_j[IW-1:0]];
    assign o_stat.kept     = kept;

    assign count_inc = r_count + 9'd1;

    // Control state: cursors, count, mode, enable bits, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= JW'(1);
            r_count  <= '0;
            r_mode   <= MODE_ALL;
            r_en     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load || i_cmd.emit_pair || i_cmd.emit_done;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.load && idx_ok) begin
                r_en[wr_addr] <= i_item.body_enabled;
            end
            if (i_cmd.load || i_cmd.emit_done) begin
                r_i     <= '0;
                r_j     <= JW'(1);
                r_count <= '0;
            end else if (i_cmd.next_row) begin
                r_i <= r_i + IW'(1);
                r_j <= JW'(r_i) + JW'(2);
            end else if (i_cmd.next_col) begin
                r_j <= r_j + JW'(1);
            end else if (i_cmd.emit_pair) begin
                r_j     <= r_j + JW'(1);
                r_count <= count_inc;
            end
        end
    end

    // Payload: row latch and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_row) begin
            r_row_moon   <= col_moon;
            r_row_parent <= col_parent;
        end
        if (i_cmd.load) begin
            r_result <= '0;
        end else if (i_cmd.emit_pair) begin
            r_result.first_body    <= i_ext[4:0];
            r_result.second_body   <= j_ext[4:0];
            r_result.pair_valid    <= 1'b1;
            r_result.scan_done     <= 1'b0;
            r_result.pairs_emitted <= count_inc;
        end else if (i_cmd.emit_done) begin
            r_result.first_body    <= '0;
            r_result.second_body   <= '0;
            r_result.pair_valid    <= 1'b0;
            r_result.scan_done     <= 1'b1;
            r_result.pairs_emitted <= r_count;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

/* src/nbody_pair_filter_enumerator_unit.sv */
// Top level of the n-body active pair enumerator.
//
//  channel   signals                          transaction
//  -------   -------------------------------  -----------------------------------
//  item in   i_start, o_busy, i_item          edge with i_start high, o_busy low
//  result    o_result_strobe, o_result        each strobed cycle, one per item
//  config    i_cfg_we, i_cfg_wdata            edge with i_cfg_we high
//
// A load item is taken while idle; its result is registered and shows on the next cycle.
// A next item resumes at the saved cursor, one RAM read per step: it skips a
// disabled row or candidate, latches the entry of an enabled row, checks each
// enabled candidate, moves on at each row end, and ends when no row is left.
// Reset clears the enable bits, the cursors, the count and the mode.
// Results cannot be held off; a new item may be started while one is shown.
`timescale 1ns / 1ps
module nbody_pair_filter_enumerator_unit
    import nbpf_pkg::*;
#(
    parameter int BODY_COUNT = BODY_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  t_item_in   i_item,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    output logic       o_result_strobe,
    output t_item_out  o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    nbpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (o_busy)
    );

    nbpf_dp #(
        .BODY_COUNT (BODY_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the n-body active pair enumerator.
`timescale 1ns / 1ps
module testbench;
    import nbpf_pkg::*;

    localparam int NB          = BODY_COUNT_DEF;
    localparam int RAND_ITEMS  = 1800;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE      = 4;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 10_000_000;

    // Mode codes with no filter of their own; the block treats them as full
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_start     = 1'b0;
    logic       o_busy;
    t_item_in   i_item      = '0;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_wdata = '0;
    logic       o_result_strobe;
    t_item_out  o_result;

    nbody_pair_filter_enumerator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Shadow of the body table, scan cursor and filter mode
    logic       sh_en     [NB];
    logic       sh_moon   [NB];
    logic [4:0] sh_parent [NB];
    int         scan_row;
    int         scan_col;
    logic [8:0] sh_count;
    logic [2:0] sh_mode;

    t_item_out  pair_results_due [$];
    t_item_out  oldest_due;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         gap_pct = 0;

    typedef struct {
        bit         is_cfg;
        logic [2:0] mode;
        t_item_in   item;
        bit         typed;
        t_item_out  res;
    } t_plan_row;

    t_plan_row plan [$];
    logic [2:0] phase_modes [12];

    function automatic void rewind_scan();
        scan_row = 0;
        scan_col = 1;
        sh_count = '0;
    endfunction

    function automatic int system_of(int b);
        return sh_moon[b] ? int'(sh_parent[b]) : b;
    endfunction

    function automatic bit keeps_pair(int a, int b);
        bit ma;
        bit mb;
        ma = sh_moon[a];
        mb = sh_moon[b];
        case (sh_mode)
            MODE_NO_MOON_MOON: return !(ma && mb);
            MODE_SAME_PARENT:  return !(ma && mb) || sh_parent[a] == sh_parent[b];
            MODE_LOCAL_SYS:    return a == 0 || b == 0 || (!ma && !mb)
                                      || system_of(a) == system_of(b);
            MODE_PARENT_SUN:   return a == 0 || b == 0 || (!ma && !mb)
                                      || (mb && int'(sh_parent[b]) == a)
                                      || (ma && int'(sh_parent[a]) == b);
            default:           return 1'b1;
        endcase
    endfunction

    // Apply one transaction to the shadow state and return its result
    function automatic t_item_out enumerate_step(t_item_in it);
        t_item_out r;
        int i;
        int j;
        r = '0;
        if (it.cmd == CMD_LOAD) begin
            sh_en[it.entry_slot]     = it.body_enabled;
            sh_moon[it.entry_slot]   = it.body_is_moon;
            sh_parent[it.entry_slot] = it.parent_body;
            rewind_scan();
            return r;
        end
        for (i = scan_row; i + 1 < NB; i++) begin
            if (!sh_en[i]) continue;
            j = (i == scan_row) ? scan_col : i + 1;
            if (j <= i) j = i + 1;
            while (j < NB) begin
                if (sh_en[j] && keeps_pair(i, j)) begin
                    sh_count        = sh_count + 9'd1;
                    scan_row        = i;
                    scan_col        = j + 1;
                    r.first_body    = 5'(i);
                    r.second_body   = 5'(j);
                    r.pair_valid    = 1'b1;
                    r.pairs_emitted = sh_count;
                    return r;
                end
                j++;
            end
        end
        // no pair left: report the pass total and start over
        r.scan_done     = 1'b1;
        r.pairs_emitted = sh_count;
        rewind_scan();
        return r;
    endfunction

    function automatic t_item_in load_item();
        t_item_in it;
        bit wide;
        wide = ($urandom_range(99) < 30);
        it.cmd          = CMD_LOAD;
        it.entry_slot   = wide ? 5'($urandom_range(31)) : 5'($urandom_range(11));
        it.body_enabled = ($urandom_range(99) < (wide ? 20 : 55));
        it.body_is_moon = 1'($urandom_range(1));
        it.parent_body  = ($urandom_range(99) < 70) ? 5'($urandom_range(11))
                                                    : 5'($urandom_range(31));
        return it;
    endfunction

    function automatic t_item_in any_item(bit force_next);
        logic [31:0] raw;
        t_item_in it;
        raw = $urandom;
        it = raw[$bits(t_item_in)-1:0];
        if (force_next) it.cmd = CMD_NEXT;
        return it;
    endfunction

    function automatic t_plan_row row_load(int idx, bit en, bit moon, int par);
        t_plan_row p;
        p.is_cfg            = 1'b0;
        p.mode              = MODE_ALL;
        p.item.cmd          = CMD_LOAD;
        p.item.entry_slot   = 5'(idx);
        p.item.body_enabled = en;
        p.item.body_is_moon = moon;
        p.item.parent_body  = 5'(par);
        p.typed             = 1'b1;
        p.res               = '0;
        return p;
    endfunction

    function automatic t_plan_row row_next();
        t_plan_row p;
        p.is_cfg   = 1'b0;
        p.mode     = MODE_ALL;
        p.item     = '1;
        p.item.cmd = CMD_NEXT;
        p.typed    = 1'b0;
        p.res      = '0;
        return p;
    endfunction

    function automatic t_plan_row row_next_exp(int fb, int sb, bit vld, bit done, int cnt);
        t_plan_row p;
        p = row_next();
        p.typed             = 1'b1;
        p.res.first_body    = 5'(fb);
        p.res.second_body   = 5'(sb);
        p.res.pair_valid    = vld;
        p.res.scan_done     = done;
        p.res.pairs_emitted = 9'(cnt);
        return p;
    endfunction

    function automatic t_plan_row row_mode(logic [2:0] m);
        t_plan_row p;
        p        = row_next();
        p.is_cfg = 1'b1;
        p.mode   = m;
        return p;
    endfunction

    task automatic send_item(input t_item_in it, input bit typed, input t_item_out typed_res,
                             output t_item_out res);
        // idle before the transaction, never inside it
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        res = enumerate_step(it);
        pair_results_due.push_back(typed ? typed_res : res);
    endtask

    task automatic set_mode(input logic [2:0] m);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pair_results_due.size() != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        sh_mode = m;
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [8:0] want,
                               input logic [8:0] seen);
        if (seen !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            if (pair_results_due.size() == 0) begin
                $error("result with no transaction pending: %p", o_result);
                fail_count++;
            end else begin
                oldest_due = pair_results_due.pop_front();
                check_field("first_body", 9'(oldest_due.first_body),
                            9'(o_result.first_body));
                check_field("second_body", 9'(oldest_due.second_body),
                            9'(o_result.second_body));
                check_field("pair_valid", 9'(oldest_due.pair_valid),
                            9'(o_result.pair_valid));
                check_field("scan_done", 9'(oldest_due.scan_done),
                            9'(o_result.scan_done));
                check_field("pairs_emitted", oldest_due.pairs_emitted,
                            o_result.pairs_emitted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_item_out got;
        int sent;
        int n;
        int kind;
        int phase;
        int next_phase;

        for (int b = 0; b < NB; b++) begin
            sh_en[b]     = 1'b0;
            sh_moon[b]   = 1'b0;
            sh_parent[b] = '0;
        end
        sh_mode = MODE_ALL;
        rewind_scan();

        phase_modes = '{MODE_ALL, MODE_NO_MOON_MOON, MODE_SAME_PARENT, MODE_LOCAL_SYS,
                        MODE_PARENT_SUN, MODE_SPARE_HI, MODE_LOCAL_SYS, MODE_PARENT_SUN,
                        MODE_SAME_PARENT, MODE_SPARE_LO, MODE_NO_MOON_MOON, MODE_SPARE_MID};

        // empty table, lone pair, pass end without done on the last pair
        plan.push_back(row_next_exp(0, 0, 1'b0, 1'b1, 0));
        plan.push_back(row_load(0, 1'b1, 1'b0, 0));
        plan.push_back(row_load(31, 1'b1, 1'b1, 31));
        plan.push_back(row_next_exp(0, 31, 1'b1, 1'b0, 1));
        plan.push_back(row_next_exp(0, 0, 1'b0, 1'b1, 1));
        // a small system: primaries, moons of 1, a moon of a moon, a stray parent
        plan.push_back(row_load(1, 1'b1, 1'b0, 0));
        plan.push_back(row_load(2, 1'b1, 1'b1, 1));
        plan.push_back(row_load(3, 1'b1, 1'b1, 1));
        plan.push_back(row_load(4, 1'b1, 1'b1, 31));
        plan.push_back(row_load(30, 1'b1, 1'b0, 17));
        plan.push_back(row_load(5, 1'b0, 1'b1, 31));
        plan.push_back(row_mode(MODE_NO_MOON_MOON));
        plan.push_back(row_next());
        plan.push_back(row_next());
        plan.push_back(row_mode(MODE_SAME_PARENT));
        plan.push_back(row_next());
        plan.push_back(row_next());
        plan.push_back(row_mode(MODE_LOCAL_SYS));
        plan.push_back(row_next());
        plan.push_back(row_next());
        plan.push_back(row_next());
        plan.push_back(row_mode(MODE_PARENT_SUN));
        plan.push_back(row_next());
        plan.push_back(row_next());
        plan.push_back(row_next());
        plan.push_back(row_mode(MODE_SPARE_HI));
        plan.push_back(row_next());

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) set_mode(plan[k].mode);
            else send_item(plan[k].item, plan[k].typed, plan[k].res, got);
        end

        sent       = 0;
        phase      = 0;
        next_phase = 0;
        while (sent < RAND_ITEMS) begin
            if (sent >= next_phase) begin
                gap_pct = (sent < RAND_ITEMS / 3) ? 21 : (sent < 2 * RAND_ITEMS / 3) ? 67 : 0;
                set_mode(phase_modes[phase % 12]);
                phase++;
                next_phase += PHASE_ITEMS;
            end
            kind = $urandom_range(99);
            if (kind < 65) begin
                // reload a few bodies, then walk the fresh pass to its end or part of the way
                n = $urandom_range(1, 6);
                repeat (n) begin
                    send_item(load_item(), 1'b0, '0, got);
                    sent++;
                end
                if ($urandom_range(1)) begin
                    do begin
                        send_item(any_item(1'b1), 1'b0, '0, got);
                        sent++;
                    end while (!got.scan_done);
                end else begin
                    repeat ($urandom_range(1, 20)) begin
                        send_item(any_item(1'b1), 1'b0, '0, got);
                        sent++;
                    end
                end
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 10)) begin
                    send_item(any_item(1'b1), 1'b0, '0, got);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(any_item(1'b0), 1'b0, '0, got);
                    sent++;
                end
            end
        end

        i_start <= 1'b0;
        while (pair_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/nbpf_pkg.sv
src/nbpf_ram.sv
src/nbpf_ctrl.sv
src/nbpf_dp.sv
src/nbody_pair_filter_enumerator_unit.sv
bench/testbench.sv
